>>> src/rsf_pkg.sv
// Shared widths, codes and structures for the rotary slop filter.
// No dependencies; every other file in src imports this package.
`timescale 1ns / 1ps
`default_nettype none

package rsf_pkg;

  // Field widths
  localparam int TimeW   = 63;
  localparam int ValueW  = 24;
  localparam int SumW    = 25;
  localparam int ThreshW = 23;
  localparam int WindowW = 48;
  localparam int CfgDataW = WindowW;

  // Saturation limits of the running sum and the passed value
  localparam logic [SumW-1:0]   SumMax = {1'b0, {(SumW-1){1'b1}}};
  localparam logic [SumW-1:0]   SumMin = {1'b1, {(SumW-1){1'b0}}};
  localparam logic [ValueW-1:0] OutMax = {1'b0, {(ValueW-1){1'b1}}};
  localparam logic [ValueW-1:0] OutMin = {1'b1, {(ValueW-1){1'b0}}};

  // Register map of the configuration port
  typedef enum logic [0:0] {
    REG_SLOP_THRESHOLD = 1'b0,
    REG_SLOP_WINDOW    = 1'b1
  } cfg_reg_t;

  // Current configuration handed to the datapath
  typedef struct packed {
    logic [ThreshW-1:0] slop_threshold;
    logic [WindowW-1:0] slop_window_ns;
  } cfg_t;

  // One result word
  typedef struct packed {
    logic [ValueW-1:0] out_value;
    logic              slop_met;
  } result_t;

endpackage

`default_nettype wire

>>> src/rsf_core.sv
// Filter datapath and tracking state: gap check, sign check, accumulate,
// threshold compare and excess saturation in one pass. Depends on rsf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rsf_core
  import rsf_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              fire,
  input  wire logic [TimeW-1:0]  item_time,
  input  wire logic [ValueW-1:0] item_value,
  input  wire cfg_t              cfg,
  output result_t                result
);

  // Tracking state
  logic [SumW-1:0]  running_sum;
  logic             threshold_reached;
  logic [TimeW-1:0] previous_time;

  logic [SumW-1:0]  running_sum_next;
  logic             threshold_reached_next;

  logic             bypass;
  logic [TimeW:0]   gap;
  logic             gap_reset;
  logic             sum_zero;
  logic             sign_reset;
  logic             reset_now;
  logic [SumW-1:0]  sum_base;
  logic             reached_base;
  logic [SumW:0]    sum_wide;
  logic [SumW-1:0]  sum_sat;
  logic [SumW-1:0]  mag;
  logic             reach;
  logic [SumW-1:0]  excess;
  logic [ValueW-1:0] pos_out;
  logic [ValueW-1:0] neg_out;
  logic             value_zero;

  // Decide whether tracking restarts for this word
  always_comb begin
    bypass     = (cfg.slop_window_ns == '0);
    gap        = {1'b0, item_time} - {1'b0, previous_time};
    gap_reset  = !gap[TimeW] &&
                 (gap[TimeW-1:0] >= {{(TimeW-WindowW){1'b0}}, cfg.slop_window_ns});
    value_zero = (item_value == '0);
    sum_zero   = (running_sum == '0);
    sign_reset = !value_zero && (sum_zero || (running_sum[SumW-1] != item_value[ValueW-1]));
    reset_now  = gap_reset || sign_reset;
    sum_base     = reset_now ? '0 : running_sum;
    reached_base = reset_now ? 1'b0 : threshold_reached;
  end

  // Accumulate, saturate and compare against the threshold
  always_comb begin
    sum_wide = {sum_base[SumW-1], sum_base} +
               {{(SumW+1-ValueW){item_value[ValueW-1]}}, item_value};
    if (sum_wide[SumW] != sum_wide[SumW-1]) begin
      sum_sat = sum_wide[SumW] ? SumMin : SumMax;
    end else begin
      sum_sat = sum_wide[SumW-1:0];
    end
    mag    = sum_sat[SumW-1] ? (~sum_sat + 1'b1) : sum_sat;
    reach  = (mag >= {{(SumW-ThreshW){1'b0}}, cfg.slop_threshold});
    excess = mag - {{(SumW-ThreshW){1'b0}}, cfg.slop_threshold};
    pos_out = (excess > {{(SumW-ValueW){1'b0}}, OutMax}) ? OutMax : excess[ValueW-1:0];
    neg_out = (excess > {{(SumW-ValueW){1'b0}}, OutMin}) ? OutMin
                                                         : (~excess[ValueW-1:0] + 1'b1);
  end

  // Select the result and the next state
  always_comb begin
    running_sum_next       = running_sum;
    threshold_reached_next = threshold_reached;
    result.out_value       = item_value;
    result.slop_met        = threshold_reached;
    if (!bypass) begin
      if (reached_base) begin
        running_sum_next       = sum_base;
        threshold_reached_next = 1'b1;
        result.out_value       = item_value;
      end else begin
        running_sum_next       = sum_sat;
        threshold_reached_next = reach;
        if (!reach || value_zero) begin
          result.out_value = '0;
        end else if (item_value[ValueW-1]) begin
          result.out_value = neg_out;
        end else begin
          result.out_value = pos_out;
        end
      end
      result.slop_met = threshold_reached_next;
    end
  end

  // Hold tracking state; advance it on each word outside bypass
  always_ff @(posedge clk) begin
    if (rst) begin
      running_sum       <= '0;
      threshold_reached <= 1'b0;
      previous_time     <= '0;
    end else if (fire && !bypass) begin
      running_sum       <= running_sum_next;
      threshold_reached <= threshold_reached_next;
      previous_time     <= item_time;
    end
  end

endmodule

`default_nettype wire

>>> src/rotary_slop_filter_unit.sv
// Top level of the rotary slop filter: configuration registers, input
// register, result register and the rsf_core datapath. Depends on rsf_pkg.
`timescale 1ns / 1ps
`default_nettype none

// Rotary slop filter. Each input word (event_time, in_value) gives exactly
// one result word (out_value, slop_met), in order. An accepted word sits in
// the input register, is filtered by rsf_core and lands in the result
// register once that register is free (empty or being taken), so its result
// shows on the output after passing the input register and the result
// register. The tracking state is updated by the combinational datapath
// between the two registers, so the block takes one word per cycle while
// the output is not stalled; ready drops only while both the input
// register and the result register are full and out_ready is low.
// Registers: index 0 is slop_threshold (23 bits, Q15.8), index 1 is
// slop_window_ns (48 bits); both reset to zero, and a window of zero passes
// words straight through. Write them only while no word is in flight;
// cfg_ready is always high.
module rotary_slop_filter_unit
  import rsf_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  // configuration write channel
  input  wire logic                cfg_valid,
  output logic                     cfg_ready,
  input  wire logic [0:0]          cfg_index,
  input  wire logic [CfgDataW-1:0] cfg_data,
  // input channel
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire logic [TimeW-1:0]    event_time,
  input  wire logic signed [ValueW-1:0] in_value,
  // result channel
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic signed [ValueW-1:0] out_value,
  output logic                     slop_met
);

  cfg_t              cfg;
  logic              s1_valid;
  logic [TimeW-1:0]  s1_time;
  logic [ValueW-1:0] s1_value;
  logic              out_free;
  logic              advance;
  result_t           core_result;

  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid || out_ready;
  assign advance   = s1_valid && out_free;
  assign in_ready  = !s1_valid || out_free;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_valid) begin
      case (cfg_reg_t'(cfg_index))
        REG_SLOP_THRESHOLD: cfg.slop_threshold <= cfg_data[ThreshW-1:0];
        REG_SLOP_WINDOW:    cfg.slop_window_ns <= cfg_data[WindowW-1:0];
        default:            cfg <= cfg;
      endcase
    end
  end

  // Input register: take a word whenever the stage is free or draining
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_time  <= event_time;
      s1_value <= in_value;
    end
  end

  rsf_core u_core (
    .clk        (clk),
    .rst        (rst),
    .fire       (advance),
    .item_time  (s1_time),
    .item_value (s1_value),
    .cfg        (cfg),
    .result     (core_result)
  );

  // Result register: hold until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_value <= core_result.out_value;
      slop_met  <= core_result.slop_met;
    end
  end

endmodule

`default_nettype wire

>>> src/rsf_checker.sv
// Port-level checks for rotary_slop_filter_unit, attached by bind.
// Depends on rsf_pkg and the top level's port list.
`timescale 1ns / 1ps
`default_nettype none

module rsf_checker
  import rsf_pkg::*;
(
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              in_valid,
  input wire logic              in_ready,
  input wire logic              out_valid,
  input wire logic              out_ready,
  input wire logic [ValueW-1:0] out_value,
  input wire logic              slop_met
);

  // A stalled result word holds
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_value) && $stable(slop_met))
    else $error("result word changed while stalled");

  // Input back-pressure only when the result side is full and stalled
  assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled with room downstream");

  // A word taken with an empty output shows a result after passing the input and result registers
  assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && !out_valid |=> ##1 out_valid)
    else $error("accepted word produced no result");

  // No result straight out of reset
  assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result valid right after reset");

endmodule

bind rotary_slop_filter_unit rsf_checker u_rsf_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_value (out_value),
  .slop_met  (slop_met)
);

`default_nettype wire

>>> test/tb_rotary_slop_filter_unit.sv
// Self-checking testbench for rotary_slop_filter_unit: directed and random event words,
// with random stalls on both channels, checked against a cycle-free model of the filter.
// Depends on rsf_pkg and the rotary_slop_filter_unit RTL in src.
`timescale 1ns / 1ps

module tb_rotary_slop_filter_unit;
  import rsf_pkg::*;

  typedef struct packed {
    logic [TimeW-1:0]  t;
    logic [ValueW-1:0] v;
  } event_word_t;

  localparam longint ValMax = 8388607;
  localparam longint ValMin = -8388608;

  logic clk;
  logic rst = 1'b1;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [0:0] cfg_index = REG_SLOP_THRESHOLD;
  logic [CfgDataW-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [TimeW-1:0] event_time = '0;
  logic signed [ValueW-1:0] in_value = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [ValueW-1:0] out_value;
  logic slop_met;

  rotary_slop_filter_unit DUT (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .event_time (event_time),
    .in_value   (in_value),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_value  (out_value),
    .slop_met   (slop_met)
  );

  // Event words waiting to be sent, and filtered words still to come back
  event_word_t pending_q[$];
  result_t     filtered_q[$];

  // Model copy of the registers and the tracking state
  logic [ThreshW-1:0] thr_reg = '0;
  logic [WindowW-1:0] win_reg = '0;
  longint             track_sum = 0;
  bit                 track_met = 1'b0;
  logic [TimeW-1:0]   track_last_time = '0;

  int err_count = 0;
  int words_in = 0;
  bit in_taken = 1'b0;
  bit out_taken = 1'b0;

  // Generator state
  logic [TimeW-1:0] gen_time = '0;
  int               gen_dir = 1;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int sgn(longint x);
    if (x == 0) return 0;
    return (x > 0) ? 1 : -1;
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Filter one event word and advance the tracking state
  function automatic result_t filter_event(logic [TimeW-1:0] t, logic signed [ValueW-1:0] v);
    result_t r;
    longint vi;
    longint s;
    longint mag;
    longint pass;
    longint unsigned gap;
    bit clear;
    vi = v;
    if (win_reg == '0) begin
      r.out_value = v;
      r.slop_met  = track_met;
      return r;
    end
    gap = longint'(t) - longint'(track_last_time);
    clear = 1'b0;
    if (t >= track_last_time && gap >= longint'(win_reg))
      clear = 1'b1;
    else if (vi != 0 && sgn(track_sum) != sgn(vi))
      clear = 1'b1;
    if (clear) begin
      track_sum = 0;
      track_met = 1'b0;
    end
    track_last_time = t;
    if (track_met) begin
      pass = vi;
    end else begin
      s = track_sum + vi;
      if (s > 16777215) s = 16777215;
      if (s < -16777216) s = -16777216;
      track_sum = s;
      mag = (s < 0) ? -s : s;
      if (mag >= longint'(thr_reg)) begin
        track_met = 1'b1;
        pass = sgn(vi) * (mag - longint'(thr_reg));
        if (pass > ValMax) pass = ValMax;
        if (pass < ValMin) pass = ValMin;
      end else begin
        pass = 0;
      end
    end
    r.out_value = pass[ValueW-1:0];
    r.slop_met  = track_met;
    return r;
  endfunction

  // Check returned words first, then log register writes and predict accepted words
  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      in_taken  <= 1'b0;
      out_taken <= 1'b0;
    end else begin
      in_taken  <= in_valid && in_ready;
      out_taken <= out_valid && out_ready;
      if (out_valid && out_ready) begin
        if (filtered_q.size() == 0) begin
          $error("unexpected word: out_value %0d slop_met %0b", out_value, slop_met);
          err_count++;
        end else begin
          want = filtered_q.pop_front();
          if (out_value !== want.out_value) begin
            $error("out_value: expected %0d, got %0d", $signed(want.out_value), out_value);
            err_count++;
          end
          if (slop_met !== want.slop_met) begin
            $error("slop_met: expected %0b, got %0b", want.slop_met, slop_met);
            err_count++;
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_SLOP_THRESHOLD: thr_reg = cfg_data[ThreshW-1:0];
          REG_SLOP_WINDOW:    win_reg = cfg_data[WindowW-1:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        filtered_q.push_back(filter_event(event_time, in_value));
        words_in++;
      end
    end
  end

  // Sender: present queued words, with a random gap after each accepted word
  int unsigned send_wait = 0;
  bit          send_calm = 1'b0;
  always @(negedge clk) begin
    event_word_t nxt;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (in_taken) begin
        if ($urandom_range(0, 31) == 0) send_calm = !send_calm;
        send_wait = send_calm ? 0 : $urandom_range(0, 6);
      end
      if (send_wait > 0 || pending_q.size() == 0) begin
        in_valid <= 1'b0;
        if (send_wait > 0) send_wait--;
      end else begin
        nxt = pending_q.pop_front();
        in_valid   <= 1'b1;
        event_time <= nxt.t;
        in_value   <= nxt.v;
      end
    end
  end

  // Receiver: random stall after each word, plus one long hold-off to back up the input
  int unsigned recv_wait = 0;
  int unsigned hold_left = 0;
  bit          hold_done = 1'b0;
  bit          recv_calm = 1'b0;
  always @(negedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_taken) begin
        if ($urandom_range(0, 31) == 0) recv_calm = !recv_calm;
        recv_wait = recv_calm ? 0 : $urandom_range(0, 6);
      end
      if (!hold_done && words_in >= 400) begin
        hold_done = 1'b1;
        hold_left = 150;
      end
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else if (recv_wait > 0) begin
        out_ready <= 1'b0;
        recv_wait--;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  task automatic queue_event(logic [TimeW-1:0] t, longint v);
    event_word_t w;
    w.t = t;
    w.v = v[ValueW-1:0];
    pending_q.push_back(w);
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [CfgDataW-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Hold until every queued word has been sent and its result returned
  task automatic wait_idle();
    do @(posedge clk);
    while (pending_q.size() != 0 || in_valid || filtered_q.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_filter(int unsigned thr, logic [WindowW-1:0] win);
    wait_idle();
    write_reg(REG_SLOP_THRESHOLD, CfgDataW'(thr));
    write_reg(REG_SLOP_WINDOW, win);
  endtask

  // Random words: mostly same-sign runs with gaps inside the window, plus noise
  task automatic queue_random(int unsigned thr, logic [WindowW-1:0] win, int n);
    int sel;
    longint mag;
    longint unsigned step;
    logic [63:0] r;
    for (int i = 0; i < n; i++) begin
      sel = $urandom_range(0, 99);
      r = rand64();
      if (win == '0)
        step = $urandom_range(0, 1000);
      else if (sel < 70)
        step = r % longint'(win);
      else if (sel < 85)
        step = longint'(win) + $urandom_range(0, 3);
      else
        step = 0;
      if (sel >= 85 && sel < 90)
        gen_time = gen_time - $urandom_range(1, 1000);
      else if (sel >= 95)
        gen_time = r[TimeW-1:0];
      else
        gen_time = gen_time + step[TimeW-1:0];
      if ($urandom_range(0, 99) < 12) gen_dir = -gen_dir;
      sel = $urandom_range(0, 99);
      if (sel < 15)
        mag = 0;
      else if (sel < 75)
        mag = $urandom_range(1, thr / 4 + 1);
      else if (sel < 88)
        mag = (2 * longint'(thr) + 1 > ValMax) ? $urandom_range(1, ValMax)
                                                 : $urandom_range(1, 2 * thr + 1);
      else
        mag = -1;
      if (mag >= 0)
        queue_event(gen_time, gen_dir * mag);
      else if (sel < 98)
        queue_event(gen_time, longint'($urandom));
      else
        queue_event(gen_time, (gen_dir > 0) ? ValMax : ValMin);
    end
  endtask

  initial begin
    logic [TimeW-1:0] t_max;
    t_max = '1;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Bypass straight after reset: extremes pass untouched
    queue_event(t_max, ValMax);
    queue_event('0, ValMin);
    queue_event(5, 0);

    // Accumulate, reach the threshold, pass, sign flip, window expiry, time going back
    set_filter(1000, 100);
    queue_event(10, 300);
    queue_event(20, 400);
    queue_event(30, 0);
    queue_event(40, 500);
    queue_event(50, 7);
    queue_event(60, -3);
    queue_event(200, -900);
    queue_event(150, -200);
    queue_event(150, 0);
    queue_event(250, 5);

    // Largest threshold and window: biggest excess of either sign
    set_filter(ValMax, '1);
    queue_event(300, -8388606);
    queue_event(310, ValMin);
    queue_event(320, ValMax);
    queue_event(330, -1);
    queue_event(340, 8388606);
    queue_event(350, ValMax);
    queue_event(t_max, 1);

    // Zero threshold: a zero delta meets it and passes zero
    set_filter(0, 1);
    queue_event(400, 0);
    queue_event(400, 0);
    queue_event(401, -1);

    gen_time = 1000;
    set_filter(2000, 1000);
    queue_random(2000, 1000, 180);
    set_filter(0, 1);
    queue_random(0, 1, 180);
    set_filter(ValMax, '1);
    queue_random(ValMax, '1, 180);
    begin
      int unsigned thr;
      thr = $urandom_range(0, 20000);
      set_filter(thr, WindowW'($urandom_range(1, 5000)));
      queue_random(thr, win_reg, 180);
    end
    begin
      int unsigned thr;
      thr = $urandom_range(0, 5000);
      set_filter(thr, '0);
      queue_random(thr, '0, 180);
    end
    begin
      int unsigned thr;
      logic [63:0] r;
      thr = $urandom_range(0, ValMax);
      r = rand64();
      set_filter(thr, r[WindowW-1:0] | 48'd1);
      queue_random(thr, r[WindowW-1:0] | 48'd1, 180);
    end
    set_filter(300, 200);
    queue_random(300, 200, 180);
    begin
      int unsigned thr;
      logic [WindowW-1:0] win;
      thr = $urandom_range(1, 3000);
      win = WindowW'($urandom_range(1, 64));
      set_filter(thr, win);
      queue_random(thr, win, 190);
    end

    wait_idle();
    repeat (8) @(posedge clk);
    if (err_count == 0) begin
      $display("PASS rotary_slop_filter_unit");
    end else begin
      $display("FAIL rotary_slop_filter_unit");
    end
    $finish;
  end

  // Stop a hung run
  initial begin
    #3000000;
    $display("FAIL rotary_slop_filter_unit");
    $finish;
  end

endmodule

>>> rotary_slop_filter_unit.f
src/rsf_pkg.sv
src/rsf_core.sv
src/rotary_slop_filter_unit.sv
src/rsf_checker.sv
test/tb_rotary_slop_filter_unit.sv
